[sv/afsq_pkg.sv]
// Shared types, constants and helper functions for the acked frame send queue.
// Used by the top level and afsq_sched (afsq_ram does not need it); depends on nothing else.
`default_nettype none

package afsq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    // Queue indexes count modulo twice the depth, so full and empty differ.
    localparam int QIDX_W = QADDR_W + 1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [15:0] WAIT_SENT_RESET = 16'd10;
    localparam logic [15:0] WAIT_ACK_RESET = 16'd30;
    localparam logic [3:0] MAX_SENDS_RESET = 4'd3;
    localparam logic [7:0] ACK_CMD_RESET = 8'd0;
    localparam logic [7:0] UNLOCK_A_RESET = 8'd1;
    localparam logic [7:0] UNLOCK_B_RESET = 8'd2;
    localparam logic [7:0] RESET_CMD_RESET = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAIT_SENT = 3'd0,
        REG_WAIT_ACK = 3'd1,
        REG_MAX_SENDS = 3'd2,
        REG_ACK_CMD = 3'd3,
        REG_UNLOCK_A = 3'd4,
        REG_UNLOCK_B = 3'd5,
        REG_RESET_CMD = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_SENT = 2'd1,
        KIND_RECV = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_TRANSMIT = 3'd1,
        ACT_REJECTED = 3'd2,
        ACT_REINIT = 3'd3,
        ACT_UNLOCK = 3'd4,
        ACT_RESET_REQ = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WAIT_SENT = 2'd1,
        MODE_WAIT_ACK = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic       needs_ack;
        logic [7:0] handle;
        logic [7:0] length;
        logic [7:0] command;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    typedef struct packed {
        logic [15:0] wait_sent;
        logic [15:0] wait_ack;
        logic [3:0]  max_sends;
        logic [7:0]  ack_cmd;
        logic [7:0]  unlock_a;
        logic [7:0]  unlock_b;
        logic [7:0]  reset_cmd;
    } cfg_t;

    function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] i);
        return (i == QIDX_W'(2 * QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [QADDR_W-1:0] idx_addr(input logic [QIDX_W-1:0] i);
        logic [QIDX_W-1:0] d;
        d = i - QIDX_W'(QUEUE_DEPTH);
        return (i >= QIDX_W'(QUEUE_DEPTH)) ? d[QADDR_W-1:0] : i[QADDR_W-1:0];
    endfunction

    // Modular wrap makes the same expression right for any depth in range.
    function automatic logic [QIDX_W-1:0] idx_count(input logic [QIDX_W-1:0] w,
                                                     input logic [QIDX_W-1:0] r);
        return (w >= r) ? w - r : w + QIDX_W'(2 * QUEUE_DEPTH) - r;
    endfunction

    function automatic logic [15:0] load_ticks(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

[sv/acked_frame_send_queue_with_retry_core.sv]
// Top level of the acked frame send queue: configuration registers and ports.
// Uses afsq_pkg and afsq_sched (which holds the queue RAM).
//
// Usage: each input word is one event (submit frame, send completed, frame
// received, timer tick), taken when in_valid is high and in_stall is low.
// Every event yields exactly one output word on the out_valid / out_stall
// channel: an action code and, for a transmit, the frame descriptor.
// Accepting an event registers it and reads the queue head from the RAM; the
// execute state then updates all state and registers the result. A new event
// is taken only once the current one is done, the RAM read coming before the
// read-modify-write of the scheduler state. A finished word may wait in the
// output register while the next event is taken; when the receiver stalls
// with a word held, the block finishes its current event only once the output
// register frees, and stalls input. Reset empties the queue, drops the current
// frame, stops the timer and loads the default configuration; no clearing pass
// is needed. Configuration is written through cfg_write / cfg_index / cfg_data
// by the user only while the block is idle; the block does not enforce this.
`default_nettype none

module acked_frame_send_queue_with_retry_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         kind,
    input  wire logic [7:0]                         frame_command,
    input  wire logic [7:0]                         frame_length,
    input  wire logic [7:0]                         payload_handle,
    input  wire logic                               needs_ack,
    input  wire logic [7:0]                         received_command,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [2:0]                              action,
    output logic [7:0]                              tx_command,
    output logic [7:0]                              tx_length,
    output logic [7:0]                              tx_handle,
    output logic                                    tx_needs_ack,
    input  wire logic                               cfg_write,
    input  wire logic [afsq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [afsq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    afsq_pkg::cfg_t  cfg_reg, cfg_next;
    afsq_pkg::desc_t in_desc;
    afsq_pkg::desc_t out_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_sent <= afsq_pkg::WAIT_SENT_RESET;
            cfg_reg.wait_ack <= afsq_pkg::WAIT_ACK_RESET;
            cfg_reg.max_sends <= afsq_pkg::MAX_SENDS_RESET;
            cfg_reg.ack_cmd <= afsq_pkg::ACK_CMD_RESET;
            cfg_reg.unlock_a <= afsq_pkg::UNLOCK_A_RESET;
            cfg_reg.unlock_b <= afsq_pkg::UNLOCK_B_RESET;
            cfg_reg.reset_cmd <= afsq_pkg::RESET_CMD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (afsq_pkg::cfg_index_t'(cfg_index))
                afsq_pkg::REG_WAIT_SENT: cfg_next.wait_sent = cfg_data;
                afsq_pkg::REG_WAIT_ACK:  cfg_next.wait_ack = cfg_data;
                afsq_pkg::REG_MAX_SENDS: cfg_next.max_sends = cfg_data[3:0];
                afsq_pkg::REG_ACK_CMD:   cfg_next.ack_cmd = cfg_data[7:0];
                afsq_pkg::REG_UNLOCK_A:  cfg_next.unlock_a = cfg_data[7:0];
                afsq_pkg::REG_UNLOCK_B:  cfg_next.unlock_b = cfg_data[7:0];
                afsq_pkg::REG_RESET_CMD: cfg_next.reset_cmd = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_desc.needs_ack = needs_ack;
    assign in_desc.handle = payload_handle;
    assign in_desc.length = frame_length;
    assign in_desc.command = frame_command;

    afsq_sched u_sched (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .in_desc         (in_desc),
        .received_command(received_command),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .out_desc        (out_desc)
    );

    assign tx_command = out_desc.command;
    assign tx_length = out_desc.length;
    assign tx_handle = out_desc.handle;
    assign tx_needs_ack = out_desc.needs_ack;

endmodule

`default_nettype wire

[sv/afsq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module afsq_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/afsq_sched.sv]
// Frame scheduler: queue indexes, current frame, mode, retry counter and timer,
// with the descriptor queue in afsq_ram. Uses afsq_pkg.
`default_nettype none

module afsq_sched (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire afsq_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            kind,
    input  wire afsq_pkg::desc_t       in_desc,
    input  wire logic [7:0]            received_command,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 action,
    output afsq_pkg::desc_t            out_desc
);

    afsq_pkg::fsm_t                 st_reg, st_next;
    afsq_pkg::mode_t                mode_reg, mode_next;
    logic [afsq_pkg::QIDX_W-1:0]    rd_reg, rd_next;
    logic [afsq_pkg::QIDX_W-1:0]    wr_reg, wr_next;
    afsq_pkg::desc_t                cur_reg, cur_next;
    logic                           cur_valid_reg, cur_valid_next;
    logic [3:0]                     sends_reg, sends_next;
    logic [15:0]                    ticks_reg, ticks_next;
    afsq_pkg::kind_t                kind_reg;
    afsq_pkg::desc_t                desc_reg;
    logic [7:0]                     rc_reg;
    logic                           out_valid_reg, out_valid_next;
    afsq_pkg::action_t              act_reg, act_next;
    afsq_pkg::desc_t                tx_reg, tx_next;

    logic                           accept;
    logic                           fire;
    logic [afsq_pkg::QIDX_W-1:0]    count;
    logic                           push;
    logic                           do_start;
    logic                           start_avail;
    logic [15:0]                    tick_dec;
    afsq_pkg::desc_t                ram_rdata;
    afsq_pkg::desc_t                head;

    assign accept = in_valid && !in_stall;
    assign in_stall = (st_reg != afsq_pkg::ST_IDLE);
    assign fire = (st_reg == afsq_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);
    assign count = afsq_pkg::idx_count(wr_reg, rd_reg);
    assign tick_dec = ticks_reg - 16'd1;

    // With an empty queue the word just submitted is the head; the RAM read
    // was issued before it was written.
    assign head = (count == '0) ? desc_reg : ram_rdata;

    afsq_ram #(
        .WIDTH (afsq_pkg::DESC_W),
        .DEPTH (afsq_pkg::QUEUE_DEPTH),
        .ADDR_W(afsq_pkg::QADDR_W)
    ) u_queue (
        .clk  (clk),
        .we   (push),
        .waddr(afsq_pkg::idx_addr(wr_reg)),
        .wdata(desc_reg),
        .re   (accept),
        .raddr(afsq_pkg::idx_addr(rd_reg)),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= afsq_pkg::ST_IDLE;
            mode_reg <= afsq_pkg::MODE_IDLE;
            rd_reg <= '0;
            wr_reg <= '0;
            cur_reg <= '0;
            cur_valid_reg <= 1'b0;
            sends_reg <= '0;
            ticks_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            mode_reg <= mode_next;
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cur_reg <= cur_next;
            cur_valid_reg <= cur_valid_next;
            sends_reg <= sends_next;
            ticks_reg <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= afsq_pkg::kind_t'(kind);
            desc_reg <= in_desc;
            rc_reg <= received_command;
        end
        if (fire)
        begin
            act_reg <= act_next;
            tx_reg <= tx_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        mode_next = mode_reg;
        rd_next = rd_reg;
        wr_next = wr_reg;
        cur_next = cur_reg;
        cur_valid_next = cur_valid_reg;
        sends_next = sends_reg;
        ticks_next = ticks_reg;
        act_next = afsq_pkg::ACT_NONE;
        tx_next = '0;
        push = 1'b0;
        do_start = 1'b0;
        start_avail = (count != '0);

        unique case (st_reg)
            afsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = afsq_pkg::ST_EXEC;
                end
            end
            afsq_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    st_next = afsq_pkg::ST_IDLE;
                    unique case (kind_reg)
                        afsq_pkg::KIND_SUBMIT:
                        begin
                            if (count == afsq_pkg::QIDX_W'(afsq_pkg::QUEUE_DEPTH))
                            begin
                                rd_next = wr_reg;
                                cur_valid_next = 1'b0;
                                cur_next = '0;
                                mode_next = afsq_pkg::MODE_IDLE;
                                ticks_next = '0;
                                act_next = afsq_pkg::ACT_REJECTED;
                            end
                            else
                            begin
                                push = 1'b1;
                                wr_next = afsq_pkg::idx_inc(wr_reg);
                                start_avail = 1'b1;
                                do_start = (mode_reg == afsq_pkg::MODE_IDLE);
                            end
                        end
                        afsq_pkg::KIND_SENT:
                        begin
                            if (cur_valid_reg && mode_reg != afsq_pkg::MODE_IDLE)
                            begin
                                if (cur_reg.needs_ack)
                                begin
                                    mode_next = afsq_pkg::MODE_WAIT_ACK;
                                    ticks_next = afsq_pkg::load_ticks(cfg.wait_ack);
                                end
                                else
                                begin
                                    do_start = 1'b1;
                                end
                            end
                        end
                        afsq_pkg::KIND_RECV:
                        begin
                            priority if (rc_reg == cfg.ack_cmd)
                            begin
                                do_start = (mode_reg == afsq_pkg::MODE_WAIT_ACK);
                            end
                            else if (rc_reg == cfg.unlock_a || rc_reg == cfg.unlock_b)
                            begin
                                act_next = afsq_pkg::ACT_UNLOCK;
                            end
                            else if (rc_reg == cfg.reset_cmd)
                            begin
                                act_next = afsq_pkg::ACT_RESET_REQ;
                            end
                        end
                        afsq_pkg::KIND_TICK:
                        begin
                            if (ticks_reg != '0)
                            begin
                                ticks_next = tick_dec;
                                if (tick_dec == '0 && (mode_reg == afsq_pkg::MODE_WAIT_SENT
                                    || mode_reg == afsq_pkg::MODE_WAIT_ACK))
                                begin
                                    if (sends_reg < cfg.max_sends && cur_valid_reg)
                                    begin
                                        sends_next = sends_reg + 4'd1;
                                        ticks_next = afsq_pkg::load_ticks(
                                            (mode_reg == afsq_pkg::MODE_WAIT_SENT)
                                            ? cfg.wait_sent : cfg.wait_ack);
                                        act_next = afsq_pkg::ACT_TRANSMIT;
                                        tx_next = cur_reg;
                                    end
                                    else
                                    begin
                                        rd_next = wr_reg;
                                        cur_valid_next = 1'b0;
                                        cur_next = '0;
                                        mode_next = afsq_pkg::MODE_IDLE;
                                        ticks_next = '0;
                                        act_next = afsq_pkg::ACT_REINIT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Pop the oldest frame and transmit it, or go idle when none waits.
                    if (do_start)
                    begin
                        if (start_avail)
                        begin
                            cur_next = head;
                            cur_valid_next = 1'b1;
                            rd_next = afsq_pkg::idx_inc(rd_reg);
                            mode_next = afsq_pkg::MODE_WAIT_SENT;
                            sends_next = 4'd1;
                            ticks_next = afsq_pkg::load_ticks(cfg.wait_sent);
                            act_next = afsq_pkg::ACT_TRANSMIT;
                            tx_next = head;
                        end
                        else
                        begin
                            cur_next = '0;
                            cur_valid_next = 1'b0;
                            mode_next = afsq_pkg::MODE_IDLE;
                            ticks_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                st_next = afsq_pkg::ST_IDLE;
            end
        endcase

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = act_reg;
    assign out_desc = tx_reg;

endmodule

`default_nettype wire

[verif/tb_acked_frame_send_queue_with_retry_core.sv]
// Self-checking testbench for the acked frame send queue with retry.
// It predicts the action for every event and compares it with the block's output words.
// Needs afsq_pkg and acked_frame_send_queue_with_retry_core.
`timescale 1ns / 1ps

module tb_acked_frame_send_queue_with_retry_core;
    import afsq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 10;
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        kind_t      kind;
        desc_t      frame;
        logic [7:0] rx_cmd;
    } event_t;

    typedef struct packed {
        action_t act;
        desc_t   frame;
    } outcome_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = '0;
    logic [7:0] frame_command = '0;
    logic [7:0] frame_length = '0;
    logic [7:0] payload_handle = '0;
    logic       needs_ack = 1'b0;
    logic [7:0] received_command = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] action;
    logic [7:0] tx_command;
    logic [7:0] tx_length;
    logic [7:0] tx_handle;
    logic       tx_needs_ack;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = REG_WAIT_SENT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Scheduler state as the testbench expects it.
    logic [15:0] cfg_wait_sent = 16'd10;
    logic [15:0] cfg_wait_ack = 16'd30;
    logic [3:0]  cfg_max_sends = 4'd3;
    logic [7:0]  cfg_ack_code = 8'd0;
    logic [7:0]  cfg_unlock_a = 8'd1;
    logic [7:0]  cfg_unlock_b = 8'd2;
    logic [7:0]  cfg_reset_code = 8'd3;
    desc_t       fifo_mem [QUEUE_DEPTH];
    int unsigned fifo_rd = 0;
    int unsigned fifo_wr = 0;
    desc_t       cur_frame = '0;
    logic        cur_valid = 1'b0;
    mode_t       cur_mode = MODE_IDLE;
    logic [3:0]  send_count = '0;
    logic [15:0] ticks_left = '0;

    outcome_t    awaited_responses [$];
    int unsigned sender_idle_pct = 6;
    int unsigned receiver_idle_pct = 78;
    int unsigned hold_order = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned events_sent = 0;
    int unsigned settings_applied = 0;
    int unsigned action_seen [8];
    int unsigned cycle_count = 0;

    acked_frame_send_queue_with_retry_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .frame_command    (frame_command),
        .frame_length     (frame_length),
        .payload_handle   (payload_handle),
        .needs_ack        (needs_ack),
        .received_command (received_command),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action           (action),
        .tx_command       (tx_command),
        .tx_length        (tx_length),
        .tx_handle        (tx_handle),
        .tx_needs_ack     (tx_needs_ack),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] wait_reload(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic int unsigned fifo_fill();
        return (fifo_wr + 2 * QUEUE_DEPTH - fifo_rd) % (2 * QUEUE_DEPTH);
    endfunction

    function automatic void drop_all();
        fifo_rd = fifo_wr;
        cur_valid = 1'b0;
        cur_frame = '0;
        cur_mode = MODE_IDLE;
        ticks_left = '0;
    endfunction

    // Pops the oldest queued frame and sends it; an empty queue leaves the scheduler idle.
    function automatic outcome_t launch_next();
        outcome_t res;
        res.act = ACT_NONE;
        res.frame = '0;
        cur_valid = 1'b0;
        cur_frame = '0;
        if (fifo_fill() > 0)
        begin
            cur_frame = fifo_mem[fifo_rd % QUEUE_DEPTH];
            cur_valid = 1'b1;
            fifo_rd = (fifo_rd + 1) % (2 * QUEUE_DEPTH);
            cur_mode = MODE_WAIT_SENT;
            send_count = 4'd1;
            ticks_left = wait_reload(cfg_wait_sent);
            res.act = ACT_TRANSMIT;
            res.frame = cur_frame;
        end
        else
        begin
            cur_mode = MODE_IDLE;
            ticks_left = '0;
        end
        return res;
    endfunction

    function automatic outcome_t scheduler_response(input event_t ev);
        outcome_t res;
        res.act = ACT_NONE;
        res.frame = '0;
        case (ev.kind)
            KIND_SUBMIT:
            begin
                if (fifo_fill() >= QUEUE_DEPTH)
                begin
                    drop_all();
                    res.act = ACT_REJECTED;
                end
                else
                begin
                    fifo_mem[fifo_wr % QUEUE_DEPTH] = ev.frame;
                    fifo_wr = (fifo_wr + 1) % (2 * QUEUE_DEPTH);
                    if (cur_mode == MODE_IDLE)
                        res = launch_next();
                end
            end
            KIND_SENT:
            begin
                if (cur_valid && cur_mode != MODE_IDLE)
                begin
                    if (cur_frame.needs_ack)
                    begin
                        cur_mode = MODE_WAIT_ACK;
                        ticks_left = wait_reload(cfg_wait_ack);
                    end
                    else
                    begin
                        ticks_left = '0;
                        res = launch_next();
                    end
                end
            end
            KIND_RECV:
            begin
                // The ack code wins over the request codes even when they are equal.
                if (ev.rx_cmd == cfg_ack_code)
                begin
                    if (cur_mode == MODE_WAIT_ACK)
                        res = launch_next();
                end
                else if (ev.rx_cmd == cfg_unlock_a || ev.rx_cmd == cfg_unlock_b)
                    res.act = ACT_UNLOCK;
                else if (ev.rx_cmd == cfg_reset_code)
                    res.act = ACT_RESET_REQ;
            end
            default:
            begin
                if (ticks_left != 16'd0)
                begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0 && cur_mode != MODE_IDLE)
                    begin
                        if (send_count < cfg_max_sends && cur_valid)
                        begin
                            send_count = send_count + 4'd1;
                            ticks_left = wait_reload(cur_mode == MODE_WAIT_SENT ?
                                                     cfg_wait_sent : cfg_wait_ack);
                            res.act = ACT_TRANSMIT;
                            res.frame = cur_frame;
                        end
                        else
                        begin
                            drop_all();
                            res.act = ACT_REINIT;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void apply_setting(input cfg_index_t idx, input logic [15:0] data);
        case (idx)
            REG_WAIT_SENT: cfg_wait_sent = data;
            REG_WAIT_ACK:  cfg_wait_ack = data;
            REG_MAX_SENDS: cfg_max_sends = data[3:0];
            REG_ACK_CMD:   cfg_ack_code = data[7:0];
            REG_UNLOCK_A:  cfg_unlock_a = data[7:0];
            REG_UNLOCK_B:  cfg_unlock_b = data[7:0];
            default:       cfg_reset_code = data[7:0];
        endcase
    endfunction

    // Events follow the frame life cycle most of the time, with the rest as noise.
    function automatic event_t random_event();
        event_t ev;
        int unsigned roll;
        int unsigned code_roll;
        ev.frame = 25'($urandom);
        roll = $urandom_range(99);
        code_roll = $urandom_range(9);
        if (code_roll < 5)
            ev.rx_cmd = cfg_ack_code;
        else if (code_roll == 5)
            ev.rx_cmd = cfg_unlock_a;
        else if (code_roll == 6)
            ev.rx_cmd = cfg_unlock_b;
        else if (code_roll == 7)
            ev.rx_cmd = cfg_reset_code;
        else
            ev.rx_cmd = 8'($urandom);
        if (cur_mode == MODE_IDLE)
        begin
            if (roll < 60)
                ev.kind = KIND_SUBMIT;
            else if (roll < 75)
                ev.kind = KIND_TICK;
            else if (roll < 87)
                ev.kind = KIND_SENT;
            else
                ev.kind = KIND_RECV;
        end
        else if (cur_mode == MODE_WAIT_SENT)
        begin
            if (roll < 45)
                ev.kind = KIND_SENT;
            else if (roll < 70)
                ev.kind = KIND_TICK;
            else if (roll < 88)
                ev.kind = KIND_SUBMIT;
            else
                ev.kind = KIND_RECV;
        end
        else
        begin
            if (roll < 40)
                ev.kind = KIND_RECV;
            else if (roll < 65)
                ev.kind = KIND_TICK;
            else if (roll < 80)
                ev.kind = KIND_SUBMIT;
            else
                ev.kind = KIND_SENT;
        end
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_event(input event_t ev);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= ev.kind;
        frame_command <= ev.frame.command;
        frame_length <= ev.frame.length;
        payload_handle <= ev.frame.handle;
        needs_ack <= ev.frame.needs_ack;
        received_command <= ev.rx_cmd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_responses.push_back(scheduler_response(ev));
        events_sent++;
        @(negedge clk);
    endtask

    task automatic submit_frame(input logic [7:0] c, input logic [7:0] l,
                                input logic [7:0] h, input logic a);
        event_t ev;
        ev.kind = KIND_SUBMIT;
        ev.frame.command = c;
        ev.frame.length = l;
        ev.frame.handle = h;
        ev.frame.needs_ack = a;
        ev.rx_cmd = 8'($urandom);
        send_event(ev);
    endtask

    task automatic send_kind(input kind_t k, input logic [7:0] rc);
        event_t ev;
        ev.kind = k;
        ev.frame = 25'($urandom);
        ev.rx_cmd = rc;
        send_event(ev);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Writes all registers back to back once the block has gone quiet.
    task automatic program_settings(input logic [15:0] ws, input logic [15:0] wa,
                                    input logic [3:0] ms, input logic [7:0] ak,
                                    input logic [7:0] ua, input logic [7:0] ub,
                                    input logic [7:0] rc);
        cfg_index_t idx;
        logic [15:0] junk;
        logic [15:0] data;
        wait_drained();
        idx = idx.first();
        repeat (idx.num())
        begin
            junk = 16'($urandom);
            case (idx)
                REG_WAIT_SENT: data = ws;
                REG_WAIT_ACK:  data = wa;
                REG_MAX_SENDS: data = {junk[15:4], ms};
                REG_ACK_CMD:   data = {junk[15:8], ak};
                REG_UNLOCK_A:  data = {junk[15:8], ua};
                REG_UNLOCK_B:  data = {junk[15:8], ub};
                default:       data = {junk[15:8], rc};
            endcase
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            apply_setting(idx, data);
            @(negedge clk);
            idx = idx.next();
        end
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // Reset configuration: queue flow, the request codes and the full-queue reject.
    task automatic test_event_handling();
        send_kind(KIND_SENT, 8'($urandom));
        send_kind(KIND_TICK, 8'($urandom));
        submit_frame(8'h00, 8'h00, 8'h00, 1'b0);
        submit_frame(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_kind(KIND_RECV, cfg_unlock_a);
        send_kind(KIND_RECV, cfg_unlock_b);
        send_kind(KIND_RECV, cfg_reset_code);
        // An ack that arrives before the send has completed changes nothing.
        send_kind(KIND_RECV, cfg_ack_code);
        send_kind(KIND_SENT, 8'($urandom));
        send_kind(KIND_SENT, 8'($urandom));
        send_kind(KIND_RECV, cfg_ack_code);
        repeat (QUEUE_DEPTH + 2)
            submit_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // A zero send wait counts as one tick; both waits run out into a modem reinit.
    task automatic test_timeouts();
        program_settings(16'd0, 16'd1, 4'd2, 8'd0, 8'd1, 8'd2, 8'd3);
        submit_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        send_kind(KIND_TICK, 8'($urandom));
        send_kind(KIND_TICK, 8'($urandom));
        submit_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        send_kind(KIND_SENT, 8'($urandom));
        send_kind(KIND_TICK, 8'($urandom));
        send_kind(KIND_TICK, 8'($urandom));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned issued;
        int unsigned burst;
        event_t ev;
        issued = 0;
        while (issued < count)
        begin
            // Submit bursts are what fill the queue far enough to be rejected.
            if ($urandom_range(99) < 8)
            begin
                burst = $urandom_range(4, 10);
                repeat (burst)
                begin
                    ev = random_event();
                    ev.kind = KIND_SUBMIT;
                    send_event(ev);
                end
                issued += burst;
            end
            else
            begin
                send_event(random_event());
                issued++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_order++;
        repeat (40)
            send_event(random_event());
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_order != hold_served)
        begin
            hold_served = hold_order;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("output word with no event waiting for it: action %0d", action);
                mismatches++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                check_field("action", 8'(want.act), 8'(action));
                check_field("tx_command", want.frame.command, tx_command);
                check_field("tx_length", want.frame.length, tx_length);
                check_field("tx_handle", want.frame.handle, tx_handle);
                check_field("tx_needs_ack", 8'(want.frame.needs_ack), 8'(tx_needs_ack));
                action_seen[want.act]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[acked_frame_send_queue_with_retry_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idle(6, 78);
        test_event_handling();
        test_timeouts();
        program_settings(16'd3, 16'd5, 4'd3, 8'h5A, 8'h11, 8'h22, 8'h33);
        test_random_traffic(300);
        // Smallest waits and a single send, with the codes overlapping each other.
        program_settings(16'd0, 16'd1, 4'd1, 8'h00, 8'hFF, 8'h00, 8'hFF);
        test_random_traffic(250);

        set_idle(78, 6);
        program_settings(16'd2, 16'd4, 4'd15, 8'hFF, 8'h80, 8'h80, 8'h7F);
        test_random_traffic(300);
        program_settings(16'hFFFF, 16'hFFFF, 4'd15, 8'h3C, 8'hC3, 8'h00, 8'hFF);
        test_random_traffic(150);

        set_idle(0, 0);
        test_backpressure();
        program_settings(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                         4'($urandom_range(1, 15)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
        test_random_traffic(300);
        program_settings(16'd1, 16'd3, 4'($urandom_range(2, 5)), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(300);

        wait_drained();
        repeat (END_CYCLES)
            @(negedge clk);
        $display("Covered %0d events under %0d register settings plus the reset values.",
                 events_sent, settings_applied);
        $display("Seen: %0d transmits, %0d rejects, %0d reinits, %0d unlock, %0d reset requests.",
                 action_seen[ACT_TRANSMIT], action_seen[ACT_REJECTED], action_seen[ACT_REINIT],
                 action_seen[ACT_UNLOCK], action_seen[ACT_RESET_REQ]);
        if (mismatches == 0)
            $display("[acked_frame_send_queue_with_retry_core] OK");
        else
            $display("[acked_frame_send_queue_with_retry_core] ERROR");
        $finish;
    end

endmodule

[acked_frame_send_queue_with_retry_core.f]
sv/afsq_pkg.sv
sv/afsq_ram.sv
sv/afsq_sched.sv
sv/acked_frame_send_queue_with_retry_core.sv
verif/tb_acked_frame_send_queue_with_retry_core.sv
